/* hw/rtl/ppm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants of the pad poll protocol master.
// ----------------------------------------------------------------------------
package ppm_pkg;

	localparam int REPLY_BYTES_DEF = 8;

	localparam logic [7:0]  ADDR_BYTE  = 8'h01;
	localparam logic [7:0]  POLL_BYTE  = 8'h42;
	localparam logic [7:0]  IDLE_BYTE  = 8'h00;
	localparam logic [7:0]  AXIS_IDLE  = 8'h80;
	localparam logic [7:0]  BYTE_CLEAR = 8'h00;
	localparam logic [3:0]  TYPE_DUAL  = 4'h7;
	localparam logic [3:0]  TYPE_ANLG  = 4'h5;
	localparam logic [15:0] BTN_INVERT = 16'hFFFF;
	localparam int          AXIS_FIRST = 4;
	localparam int          AXIS_COUNT = 4;
	localparam int          CLEAR_LOW  = 4;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_ADDR = 4'b0010,
		PH_HEAD = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

endpackage

/* hw/rtl/pad_poll_protocol_master_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_poll_protocol_master_unit
// Poll master for a game-pad serial port: select, address, header, reply
// bytes, then decoded buttons and analog axes.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid / in_ready  kind, port, rx_byte, acked
// out      out_valid/ out_ready tx_valid, tx_byte, select_active, port_select,
//                               done_res, buttons, is_analog, right_x, right_y,
//                               left_x, left_y
//
// One request in, one result out; a request may be taken in every cycle
// that in_ready is high. State advances as the request is taken and the result
// lands in a single output register, shown the next cycle.
// in_ready is low only while a result is held and out_ready is low.
// arst_n clears the poll state, presets the reply bytes and empties the output register.
// ----------------------------------------------------------------------------
module pad_poll_protocol_master_unit #(
	parameter int REPLY_BYTES = ppm_pkg::REPLY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic        port,
	input  logic [7:0]  rx_byte,
	input  logic        acked,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        select_active,
	output logic        port_select,
	output logic        done_res,
	output logic [15:0] buttons,
	output logic        is_analog,
	output logic [7:0]  right_x,
	output logic [7:0]  right_y,
	output logic [7:0]  left_x,
	output logic [7:0]  left_y
);

	localparam int IDX_W = $clog2(REPLY_BYTES);
	localparam int LEN_W = $clog2(REPLY_BYTES + 1);
	localparam int CMP_W = LEN_W + 1;
	localparam int RAW_W = 6;

	ppm_pkg::phase_t  phase_q, phase_nx;
	logic [IDX_W-1:0] idx_q, idx_nx;
	logic [LEN_W-1:0] len_q, len_nx;
	logic [3:0]       type_q, type_nx;
	logic             port_q, port_nx;
	logic [7:0]       store_q  [REPLY_BYTES];
	logic [7:0]       store_nx [REPLY_BYTES];
	logic [7:0]       axis_w   [ppm_pkg::AXIS_COUNT];

	logic [RAW_W-1:0] len_raw;
	logic             take;
	logic             fin_def, fin_data;

	logic        r_tx_v, r_sel, r_done, r_ana;
	logic [7:0]  r_tx_b;
	logic [15:0] r_btn;
	logic [7:0]  r_axis [ppm_pkg::AXIS_COUNT];

	logic        res_valid_q;
	logic        tx_valid_q, select_q, port_sel_q, done_q, analog_q;
	logic [7:0]  tx_byte_q;
	logic [15:0] buttons_q;
	logic [7:0]  axis_q [ppm_pkg::AXIS_COUNT];

	assign in_ready = !res_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign len_raw  = (RAW_W'(rx_byte[3:0]) + RAW_W'(1)) << 1;

	genvar g;
	generate
		for (g = 0; g < ppm_pkg::AXIS_COUNT; g++) begin : g_axis
			if (ppm_pkg::AXIS_FIRST + g < REPLY_BYTES) begin : g_in
				assign axis_w[g] = store_nx[ppm_pkg::AXIS_FIRST + g];
			end else begin : g_out
				assign axis_w[g] = ppm_pkg::AXIS_IDLE;
			end
		end
	endgenerate

	always_comb begin
		phase_nx = phase_q;
		idx_nx   = idx_q;
		len_nx   = len_q;
		type_nx  = type_q;
		port_nx  = port_q;
		store_nx = store_q;
		fin_def  = 1'b0;
		fin_data = 1'b0;
		r_tx_v   = 1'b0;
		r_tx_b   = ppm_pkg::IDLE_BYTE;
		r_sel    = 1'b0;
		if (kind == ppm_pkg::KIND_START) begin
			port_nx = port;
			for (int i = 0; i < REPLY_BYTES; i++) begin
				store_nx[i] = (i < ppm_pkg::CLEAR_LOW) ? ppm_pkg::BYTE_CLEAR : ppm_pkg::AXIS_IDLE;
			end
			type_nx  = '0;
			len_nx   = '0;
			idx_nx   = '0;
			phase_nx = ppm_pkg::PH_ADDR;
			r_tx_v   = 1'b1;
			r_tx_b   = ppm_pkg::ADDR_BYTE;
			r_sel    = 1'b1;
		end else begin
			case (phase_q)
				ppm_pkg::PH_ADDR: begin
					if (!acked) begin
						fin_def = 1'b1;
					end else begin
						phase_nx = ppm_pkg::PH_HEAD;
						r_tx_v   = 1'b1;
						r_tx_b   = ppm_pkg::POLL_BYTE;
						r_sel    = 1'b1;
					end
				end
				ppm_pkg::PH_HEAD: begin
					store_nx[0] = rx_byte;
					if (!acked) begin
						fin_def = 1'b1;
					end else begin
						type_nx = rx_byte[7:4];
						if (len_raw > RAW_W'(REPLY_BYTES)) begin
							len_nx = LEN_W'(REPLY_BYTES);
						end else begin
							len_nx = LEN_W'(len_raw);
						end
						idx_nx   = IDX_W'(1);
						phase_nx = ppm_pkg::PH_DATA;
						r_tx_v   = 1'b1;
						r_tx_b   = ppm_pkg::IDLE_BYTE;
						r_sel    = 1'b1;
					end
				end
				ppm_pkg::PH_DATA: begin
					store_nx[idx_q] = rx_byte;
					if ((CMP_W'(idx_q) + CMP_W'(1) >= CMP_W'(len_q)) || !acked) begin
						fin_data = 1'b1;
					end else begin
						idx_nx = idx_q + IDX_W'(1);
						r_tx_v = 1'b1;
						r_tx_b = ppm_pkg::IDLE_BYTE;
						r_sel  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (fin_def || fin_data) begin
			phase_nx = ppm_pkg::PH_IDLE;
		end
	end

	always_comb begin
		r_done = fin_def || fin_data;
		r_btn  = '0;
		r_ana  = 1'b0;
		for (int i = 0; i < ppm_pkg::AXIS_COUNT; i++) begin
			r_axis[i] = ppm_pkg::AXIS_IDLE;
		end
		if (fin_data) begin
			r_btn = {store_nx[3], store_nx[2]} ^ ppm_pkg::BTN_INVERT;
			if (type_q == ppm_pkg::TYPE_DUAL || type_q == ppm_pkg::TYPE_ANLG) begin
				r_ana  = 1'b1;
				r_axis = axis_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ppm_pkg::PH_IDLE;
			idx_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			port_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_nx;
			idx_q   <= idx_nx;
			len_q   <= len_nx;
			type_q  <= type_nx;
			port_q  <= port_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REPLY_BYTES; i++) begin
				store_q[i] <= (i < ppm_pkg::CLEAR_LOW) ? ppm_pkg::BYTE_CLEAR : ppm_pkg::AXIS_IDLE;
			end
		end else if (take) begin
			store_q <= store_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tx_valid_q <= r_tx_v;
			tx_byte_q  <= r_tx_b;
			select_q   <= r_sel;
			port_sel_q <= port_nx;
			done_q     <= r_done;
			buttons_q  <= r_btn;
			analog_q   <= r_ana;
			axis_q     <= r_axis;
		end
	end

	assign out_valid     = res_valid_q;
	assign tx_valid      = tx_valid_q;
	assign tx_byte       = tx_byte_q;
	assign select_active = select_q;
	assign port_select   = port_sel_q;
	assign done_res      = done_q;
	assign buttons       = buttons_q;
	assign is_analog     = analog_q;
	assign right_x       = axis_q[0];
	assign right_y       = axis_q[1];
	assign left_x        = axis_q[2];
	assign left_y        = axis_q[3];

endmodule

/* hw/rtl/ppm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_checker
// Port-level checks of the pad poll protocol master, bound to the top level.
// ----------------------------------------------------------------------------
module ppm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        tx_valid,
	input logic        select_active,
	input logic        done_res,
	input logic [15:0] buttons,
	input logic        is_analog
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(buttons) && $stable(done_res))
		else $error("result dropped or changed while stalled");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !select_active && !tx_valid)
		else $error("select or transmit left active on finishing result");

	a_tx_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> select_active && !done_res)
		else $error("transmit requested without select");

	a_idle_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> buttons == 16'h0000 && !is_analog)
		else $error("pad data shown before poll finished");

endmodule

bind pad_poll_protocol_master_unit ppm_checker u_ppm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.tx_valid      (tx_valid),
	.select_active (select_active),
	.done_res      (done_res),
	.buttons       (buttons),
	.is_analog     (is_analog)
);
